FILE: hdl/i2a_pkg.sv
package i2a_pkg;

	localparam int VALUE_BITS_DEF = 64;

	// Digit counters hold up to the longest text, 22 octal digits.
	localparam int CNT_W      = 5;
	localparam int HEX_CHARS  = 16;
	localparam int HEX_BITS   = 64;
	localparam int OCT_DIGITS = 22;
	localparam int OCT_BITS   = 66;

	localparam logic [2:0] OP_SDEC   = 3'd0;
	localparam logic [2:0] OP_UDEC   = 3'd1;
	localparam logic [2:0] OP_OCT    = 3'd2;
	localparam logic [2:0] OP_HEXMIN = 3'd3;
	localparam logic [2:0] OP_HEXFIX = 3'd4;
	localparam logic [2:0] OP_HEXPAD = 3'd5;
	localparam logic [2:0] OP_PTR    = 3'd6;
	localparam logic [2:0] OP_NONE   = 3'd7;

	localparam logic [1:0] FORM_DEC = 2'd0;
	localparam logic [1:0] FORM_OCT = 2'd1;
	localparam logic [1:0] FORM_HEX = 2'd2;

	localparam logic [1:0] SEL_DIGIT = 2'd0;
	localparam logic [1:0] SEL_MINUS = 2'd1;
	localparam logic [1:0] SEL_ZERO  = 2'd2;
	localparam logic [1:0] SEL_X     = 2'd3;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_X     = 8'h78;

	typedef struct packed {
		logic [63:0] value_bits;
		logic [1:0]  width_code;
		logic [2:0]  opcode;
	} item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_char;
	} text_t;

	typedef struct packed {
		logic       ld_item;
		logic       prep;
		logic [1:0] form;
		logic       full;
		logic       sgn;
		logic       hex_fit;
		logic       dd_step;
		logic       take_bcd;
		logic       shift_dig;
		logic       out_ld;
		logic [1:0] char_sel;
		logic       out_last;
	} cmd_t;

	typedef struct packed {
		logic             neg;
		logic             dig_zero;
		logic [CNT_W-1:0] nib;
	} stat_t;

	// Decimal digits of the largest unsigned value of vb bits.
	function automatic int dec_digits(input int vb);
		return (vb * 30103 + 99999) / 100000;
	endfunction

endpackage

FILE: hdl/integer_to_ascii_converter.sv
// Integer to ASCII text converter.
// An item (value, operand width, opcode) enters on the item channel and
// comes back as ASCII characters on the text channel, most significant
// first, with last_char set on the final one of the conversion. Opcode 7
// is consumed and produces no text. The cfg channel writes pad_long_hex,
// which is always ready and should only be written while no item is in work.
// Steps: the item is latched and the operand prepared, then characters are
// emitted in turn and suppressed leading zeros are skipped. Decimal first
// runs the binary to BCD unit, which takes four bits per cycle, and then
// moves the BCD result out. Items are worked one at a time; item_ready is
// high only between items, and a new item can enter while the last
// character still waits in the output register. When the receiver stalls,
// the character stays in that register and the next character waits,
// though BCD steps and the skipping of leading zeros go on. Reset returns
// the block to idle, drops any pending character and clears pad_long_hex.
module integer_to_ascii_converter #(
	parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  i2a_pkg::item_t item,
	output logic           text_valid,
	input  logic           text_ready,
	output i2a_pkg::text_t text,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           pad_long_hex
);
	import i2a_pkg::*;

	cmd_t  cmd;
	stat_t st;

	i2a_ctrl #(
		.VALUE_BITS(VALUE_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.opcode      (item.opcode),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.pad_long_hex(pad_long_hex),
		.text_valid  (text_valid),
		.text_ready  (text_ready),
		.cmd         (cmd),
		.st          (st)
	);

	i2a_datapath #(
		.VALUE_BITS(VALUE_BITS)
	) u_datapath (
		.clk (clk),
		.item(item),
		.cmd (cmd),
		.st  (st),
		.text(text)
	);

endmodule

FILE: hdl/i2a_datapath.sv
module i2a_datapath #(
	parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
	input  logic          clk,
	input  i2a_pkg::item_t item,
	input  i2a_pkg::cmd_t  cmd,
	output i2a_pkg::stat_t st,
	output i2a_pkg::text_t text
);
	import i2a_pkg::*;

	localparam int ND    = dec_digits(VALUE_BITS);
	localparam int BCD_W = 4 * ND;
	localparam int BW    = 4 * ((VALUE_BITS + 3) / 4);
	localparam int DIGW  = (BCD_W > OCT_BITS) ? BCD_W : OCT_BITS;

	logic [VALUE_BITS-1:0] val_q;
	logic [1:0]            wc_q;
	logic [BW-1:0]         bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [DIGW-1:0]       dig_q;
	logic                  oct_q;
	text_t                 text_q;

	logic [6:0]            w_base;
	logic [6:0]            w_item;
	logic [6:0]            w_eff;
	logic [CNT_W-1:0]      nib_item;
	logic [CNT_W-1:0]      nib_eff;
	logic [VALUE_BITS-1:0] mask;
	logic [VALUE_BITS-1:0] masked;
	logic [VALUE_BITS-1:0] top;
	logic [VALUE_BITS-1:0] mag;
	logic                  neg;
	logic                  sign_bit;
	logic [6:0]            sh_bin;
	logic [6:0]            sh_hex;
	logic [DIGW-1:0]       mag_ext;
	logic [DIGW-1:0]       oct_load;
	logic [DIGW-1:0]       hex_load;
	logic [BCD_W-1:0]      dd_next;
	logic [3:0]            cur_dig;
	logic [7:0]            dig_char;
	logic [7:0]            ch;

	always_comb begin
		w_base   = 7'd8 << wc_q;
		w_item   = (w_base < 7'(VALUE_BITS)) ? w_base : 7'(VALUE_BITS);
		w_eff    = cmd.full ? 7'(VALUE_BITS) : w_item;
		nib_item = CNT_W'((w_item + 7'd3) >> 2);
		nib_eff  = CNT_W'((w_eff + 7'd3) >> 2);
		for (int i = 0; i < VALUE_BITS; i++) begin
			mask[i] = (i < int'(w_eff));
		end
		// The sign seen by the controller is the top bit of the item's own width.
		sign_bit = 1'b0;
		for (int i = 0; i < VALUE_BITS; i++) begin
			if (i == int'(w_item) - 1) begin
				sign_bit = val_q[i];
			end
		end
		masked = val_q & mask;
		// The operand's top bit is the only bit of the mask not shifted over by its neighbor.
		top    = mask & ~(mask >> 1);
		neg    = cmd.sgn & (|(masked & top));
		mag    = neg ? ((~masked + VALUE_BITS'(1)) & mask) : masked;
		sh_bin = 7'(BW) - {nib_item, 2'b00};
		sh_hex = cmd.hex_fit ? (7'(HEX_BITS) - {nib_eff, 2'b00}) : 7'd0;
		mag_ext  = DIGW'(mag);
		oct_load = mag_ext << (DIGW - OCT_BITS);
		hex_load = (mag_ext << (DIGW - HEX_BITS)) << sh_hex;
	end

	// Four shift-and-add-3 passes of the binary to BCD conversion per step.
	always_comb begin
		dd_next = bcd_q;
		for (int s = 0; s < 4; s++) begin
			for (int d = 0; d < ND; d++) begin
				if (dd_next[4*d +: 4] >= 4'd5) begin
					dd_next[4*d +: 4] = dd_next[4*d +: 4] + 4'd3;
				end
			end
			dd_next = {dd_next[BCD_W-2:0], bin_q[BW-1-s]};
		end
	end

	always_comb begin
		cur_dig  = oct_q ? {1'b0, dig_q[DIGW-1 -: 3]} : dig_q[DIGW-1 -: 4];
		dig_char = (cur_dig < 4'd10) ? (CH_ZERO + {4'b0, cur_dig})
		                             : (CH_A + {4'b0, cur_dig} - 8'd10);
		unique case (cmd.char_sel)
			SEL_DIGIT: ch = dig_char;
			SEL_MINUS: ch = CH_MINUS;
			SEL_ZERO:  ch = CH_ZERO;
			SEL_X:     ch = CH_X;
			default:   ch = dig_char;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			val_q <= item.value_bits[VALUE_BITS-1:0];
			wc_q  <= item.width_code;
		end
		if (cmd.prep) begin
			oct_q <= (cmd.form == FORM_OCT);
			unique case (cmd.form)
				FORM_DEC: begin
					bin_q <= BW'(mag) << sh_bin;
					bcd_q <= '0;
				end
				FORM_OCT: dig_q <= oct_load;
				FORM_HEX: dig_q <= hex_load;
				default: ;
			endcase
		end
		if (cmd.dd_step) begin
			bcd_q <= dd_next;
			bin_q <= bin_q << 4;
		end
		if (cmd.take_bcd) begin
			dig_q <= DIGW'(bcd_q) << (DIGW - BCD_W);
			oct_q <= 1'b0;
		end
		if (cmd.shift_dig) begin
			dig_q <= oct_q ? (dig_q << 3) : (dig_q << 4);
		end
		if (cmd.out_ld) begin
			text_q.out_char  <= ch;
			text_q.last_char <= cmd.out_last;
		end
	end

	assign st.neg      = sign_bit;
	assign st.dig_zero = (cur_dig == 4'd0);
	assign st.nib      = nib_item;
	assign text        = text_q;

endmodule

FILE: hdl/i2a_ctrl.sv
module i2a_ctrl #(
	parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  logic [2:0]    opcode,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          pad_long_hex,
	output logic          text_valid,
	input  logic          text_ready,
	output i2a_pkg::cmd_t  cmd,
	input  i2a_pkg::stat_t st
);
	import i2a_pkg::*;

	localparam int ND = dec_digits(VALUE_BITS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_CONV = 3'd2;
	localparam logic [2:0] S_TAKE = 3'd3;
	localparam logic [2:0] S_PFXA = 3'd4;
	localparam logic [2:0] S_PFXB = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;

	logic [2:0]       state_q, state_d;
	logic [2:0]       op_q, op_d;
	logic             pad_q;
	logic             neg_q, neg_d;
	logic             supp_q, supp_d;
	logic [CNT_W-1:0] rem_q, rem_d;
	logic [CNT_W-1:0] step_q, step_d;
	logic             tv_q;
	logic             accept;
	logic             free;

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign free       = !tv_q || text_ready;
	assign cfg_ready  = 1'b1;
	assign text_valid = tv_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		op_d    = op_q;
		neg_d   = neg_q;
		supp_d  = supp_q;
		rem_d   = rem_q;
		step_d  = step_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.ld_item = accept;
				if (accept && opcode != OP_NONE) begin
					op_d    = opcode;
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				neg_d    = 1'b0;
				unique case (op_q)
					OP_SDEC, OP_UDEC: begin
						cmd.form = FORM_DEC;
						cmd.sgn  = (op_q == OP_SDEC);
						neg_d    = (op_q == OP_SDEC) && st.neg;
						rem_d    = CNT_W'(ND);
						supp_d   = 1'b1;
						step_d   = st.nib;
						state_d  = S_CONV;
					end
					OP_OCT: begin
						cmd.form = FORM_OCT;
						rem_d    = CNT_W'(OCT_DIGITS);
						supp_d   = 1'b1;
						state_d  = S_EMIT;
					end
					OP_HEXMIN: begin
						cmd.form = FORM_HEX;
						rem_d    = CNT_W'(HEX_CHARS);
						supp_d   = 1'b1;
						state_d  = S_EMIT;
					end
					OP_HEXFIX: begin
						cmd.form    = FORM_HEX;
						cmd.hex_fit = 1'b1;
						rem_d       = st.nib;
						supp_d      = 1'b0;
						state_d     = S_EMIT;
					end
					OP_HEXPAD: begin
						cmd.form = FORM_HEX;
						cmd.full = 1'b1;
						rem_d    = CNT_W'(HEX_CHARS);
						supp_d   = !pad_q;
						state_d  = S_EMIT;
					end
					OP_PTR: begin
						cmd.form = FORM_HEX;
						cmd.full = 1'b1;
						rem_d    = CNT_W'(HEX_CHARS);
						supp_d   = 1'b0;
						state_d  = S_PFXA;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_CONV: begin
				cmd.dd_step = 1'b1;
				step_d      = step_q - CNT_W'(1);
				if (step_q == CNT_W'(1)) begin
					state_d = S_TAKE;
				end
			end
			S_TAKE: begin
				cmd.take_bcd = 1'b1;
				state_d      = neg_q ? S_PFXA : S_EMIT;
			end
			S_PFXA: begin
				if (free) begin
					cmd.out_ld   = 1'b1;
					cmd.char_sel = (op_q == OP_PTR) ? SEL_ZERO : SEL_MINUS;
					state_d      = (op_q == OP_PTR) ? S_PFXB : S_EMIT;
				end
			end
			S_PFXB: begin
				if (free) begin
					cmd.out_ld   = 1'b1;
					cmd.char_sel = SEL_X;
					state_d      = S_EMIT;
				end
			end
			S_EMIT: begin
				// Leading zeros are dropped without a word, but the final digit always goes out.
				priority if (supp_q && st.dig_zero && rem_q != CNT_W'(1)) begin
					cmd.shift_dig = 1'b1;
					rem_d         = rem_q - CNT_W'(1);
				end else if (free) begin
					cmd.out_ld    = 1'b1;
					cmd.char_sel  = SEL_DIGIT;
					cmd.out_last  = (rem_q == CNT_W'(1));
					cmd.shift_dig = 1'b1;
					rem_d         = rem_q - CNT_W'(1);
					supp_d        = 1'b0;
					if (rem_q == CNT_W'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_NONE;
			pad_q   <= 1'b0;
			neg_q   <= 1'b0;
			supp_q  <= 1'b0;
			rem_q   <= '0;
			step_q  <= '0;
			tv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			neg_q   <= neg_d;
			supp_q  <= supp_d;
			rem_q   <= rem_d;
			step_q  <= step_d;
			if (cfg_valid) begin
				pad_q <= pad_long_hex;
			end
			if (cmd.out_ld) begin
				tv_q <= 1'b1;
			end else if (text_ready) begin
				tv_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/i2a_check.sv
module i2a_check (
	input logic           clk,
	input logic           arst_n,
	input logic           item_valid,
	input logic           item_ready,
	input i2a_pkg::item_t item,
	input logic           text_valid,
	input logic           text_ready,
	input i2a_pkg::text_t text
);
	import i2a_pkg::*;

	// A real item keeps the input closed for at least the next cycle.
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.opcode != OP_NONE |=> !item_ready)
		else $error("item_ready high right after an item was taken");

	// Between items, only the final character of a conversion may be waiting.
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && item_ready |-> text.last_char)
		else $error("block idle while a non-final character is pending");

	a_text_hold: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_ready |=> text_valid)
		else $error("text_valid dropped before the word was taken");

	a_text_stable: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_ready |=> $stable(text))
		else $error("text word changed while stalled");

endmodule

bind integer_to_ascii_converter i2a_check u_i2a_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.item_valid(item_valid),
	.item_ready(item_ready),
	.item      (item),
	.text_valid(text_valid),
	.text_ready(text_ready),
	.text      (text)
);

FILE: dv/integer_to_ascii_converter_test.sv
`timescale 1ns / 100ps

module integer_to_ascii_converter_test;
	import i2a_pkg::*;

	localparam int VALUE_BITS = VALUE_BITS_DEF;
	localparam int SETTLE_CYCLES = 60;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   item_valid = 1'b0;
	logic   item_ready;
	item_t  item = '0;
	logic   text_valid;
	logic   text_ready = 1'b0;
	text_t  text;
	logic   cfg_valid = 1'b0;
	logic   cfg_ready;
	logic   pad_long_hex = 1'b0;

	item_t  pending_items[$];
	text_t  expected_text[$];
	text_t  exp_char;
	logic   pad_model = 1'b0;
	int     errors = 0;
	int     burst_left = 1;
	int     gap_left = 0;
	int     chars_seen = 0;
	int     holdoff_left = 0;
	bit     holdoff_done = 1'b0;
	int     stall_mode = 0;
	int     mode_left = 0;

	integer_to_ascii_converter i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.text_valid  (text_valid),
		.text_ready  (text_ready),
		.text        (text),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.pad_long_hex(pad_long_hex)
	);

	always #6 clk = ~clk;

	function automatic logic [7:0] hex_char(input logic [63:0] x);
		logic [3:0] d;
		d = x[3:0];
		if (d < 4'd10) return CH_ZERO + {4'd0, d};
		return CH_A + {4'd0, d - 4'd10};
	endfunction

	// Works out the characters that one accepted item must produce.
	function automatic void predict_text(input item_t it, input logic pad);
		int          w;
		int          n;
		int          nd;
		int          cnt;
		int          i;
		bit          fixed;
		logic [63:0] m;
		logic [63:0] v;
		logic [63:0] v64;
		logic [63:0] base;
		logic [63:0] rem;
		logic [7:0]  txt[0:23];
		logic [7:0]  rev[0:23];
		text_t       t;
		w = 8 << it.width_code;
		if (w > VALUE_BITS) w = VALUE_BITS;
		m = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
		v = it.value_bits & m;
		v64 = (VALUE_BITS >= 64) ? it.value_bits
			: (it.value_bits & ((64'd1 << VALUE_BITS) - 64'd1));
		n = 0;
		cnt = 0;
		fixed = 1'b0;
		base = 64'd10;
		case (it.opcode)
			OP_SDEC: begin
				if (v[w-1]) begin
					txt[0] = CH_MINUS;
					n = 1;
					// The most negative value negates onto itself, its true magnitude.
					v = (~v + 64'd1) & m;
				end
			end
			OP_UDEC: base = 64'd10;
			OP_OCT: base = 64'd8;
			OP_HEXMIN: base = 64'd16;
			OP_HEXFIX: begin
				fixed = 1'b1;
				cnt = (w + 3) / 4;
			end
			OP_HEXPAD: begin
				v = v64;
				base = 64'd16;
				if (pad) begin
					fixed = 1'b1;
					cnt = 16;
				end
			end
			OP_PTR: begin
				txt[0] = CH_ZERO;
				txt[1] = CH_X;
				n = 2;
				v = v64;
				fixed = 1'b1;
				cnt = 16;
			end
			default: return;
		endcase
		if (fixed) begin
			for (i = cnt; i > 0; i--) begin
				txt[n] = hex_char(v >> ((i - 1) * 4));
				n++;
			end
		end else begin
			nd = 0;
			do begin
				rem = v % base;
				rev[nd] = hex_char(rem);
				nd++;
				v = v / base;
			end while (v != 64'd0);
			for (i = nd - 1; i >= 0; i--) begin
				txt[n] = rev[i];
				n++;
			end
		end
		for (i = 0; i < n; i++) begin
			t.out_char = txt[i];
			t.last_char = (i == n - 1);
			expected_text.push_back(t);
		end
	endfunction

	function automatic logic [63:0] rand_value();
		logic [63:0] r;
		int          k;
		r = {$urandom, $urandom};
		k = $urandom_range(0, 63);
		case ($urandom_range(0, 5))
			0: return 64'($urandom_range(0, 20));
			1: return r;
			2: return r | (64'd1 << k);
			3: return 64'd1 << k;
			4: return ~64'd0 >> k;
			default: return r >> k;
		endcase
	endfunction

	task automatic queue_random(input int count);
		item_t it;
		int    taken;
		taken = 0;
		while (taken < count) begin
			it.value_bits = rand_value();
			it.width_code = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 19) == 0) begin
				it.opcode = OP_NONE;
			end else begin
				it.opcode = 3'($urandom_range(0, 6));
				taken++;
			end
			pending_items.push_back(it);
		end
	endtask

	task automatic queue_item(input logic [63:0] v, input logic [1:0] wc, input logic [2:0] op);
		item_t it;
		it.value_bits = v;
		it.width_code = wc;
		it.opcode = op;
		pending_items.push_back(it);
	endtask

	// The register may only change with no conversion in work.
	task automatic wait_idle();
		while (pending_items.size() != 0 || item_valid || expected_text.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_pad(input logic val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		pad_long_hex <= val;
		do @(posedge clk); while (!cfg_ready);
		pad_model = val;
		cfg_valid <= 1'b0;
	endtask

	// Sender: items go out in bursts separated by gaps of random length.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_ready) begin
			if (item_valid) predict_text(item, pad_model);
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				item <= pending_items.pop_front();
				item_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 16);
					if ($urandom_range(0, 2) == 0) gap_left = 0;
					else gap_left = $urandom_range(1, $urandom_range(0, 1) ? 6 : 45);
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: checks each character word and stalls on its own pattern.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_ready <= 1'b0;
		end else begin
			if (text_valid && text_ready) begin
				chars_seen++;
				if (expected_text.size() == 0) begin
					errors++;
					$display("%0t: unexpected character, expected none, got %h last %b",
						$time, text.out_char, text.last_char);
				end else begin
					exp_char = expected_text.pop_front();
					if (text.out_char !== exp_char.out_char) begin
						errors++;
						$display("%0t: out_char expected %h, got %h",
							$time, exp_char.out_char, text.out_char);
					end
					if (text.last_char !== exp_char.last_char) begin
						errors++;
						$display("%0t: last_char expected %b, got %b",
							$time, exp_char.last_char, text.last_char);
					end
				end
			end
			// One long hold-off lets the block fill up and stall its input.
			if (!holdoff_done && chars_seen >= 600) begin
				holdoff_left = 400;
				holdoff_done = 1'b1;
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(10, 80);
			end else begin
				mode_left--;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				text_ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: text_ready <= 1'b1;
					1: text_ready <= ($urandom_range(0, 3) != 0);
					2: text_ready <= ($urandom_range(0, 3) == 0);
					default: text_ready <= ~text_ready;
				endcase
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_pad(1'b0);
		queue_item(64'd0, 2'd3, OP_SDEC);
		queue_item(64'h8000_0000_0000_0000, 2'd3, OP_SDEC);
		queue_item(64'hFFFF_FFFF_FFFF_FF80, 2'd0, OP_SDEC);
		queue_item(~64'd0, 2'd0, OP_SDEC);
		queue_item(64'h0000_0000_0000_007F, 2'd0, OP_SDEC);
		queue_item(64'h0000_0000_0000_8000, 2'd1, OP_SDEC);
		queue_item(64'h0000_0000_8000_0000, 2'd2, OP_SDEC);
		queue_item(~64'd0, 2'd3, OP_UDEC);
		queue_item(64'd0, 2'd0, OP_UDEC);
		queue_item(~64'd0, 2'd1, OP_UDEC);
		queue_item(~64'd0, 2'd3, OP_OCT);
		queue_item(64'd0, 2'd1, OP_OCT);
		queue_item(~64'd0, 2'd2, OP_HEXMIN);
		queue_item(64'd0, 2'd3, OP_HEXMIN);
		queue_item(64'h1234_5678_9ABC_DE0A, 2'd0, OP_HEXFIX);
		queue_item(64'd0, 2'd3, OP_HEXFIX);
		queue_item(64'hFEDC_BA98_7654_3210, 2'd3, OP_HEXFIX);
		queue_item(64'h0000_0000_0000_1234, 2'd0, OP_HEXPAD);
		queue_item(64'd0, 2'd2, OP_HEXPAD);
		queue_item(~64'd0, 2'd1, OP_PTR);
		queue_item(64'd0, 2'd0, OP_PTR);
		queue_item({$urandom, $urandom}, 2'($urandom_range(0, 3)), OP_NONE);
		wait_idle();

		write_pad(1'b1);
		queue_item(64'd0, 2'd3, OP_HEXPAD);
		queue_item(64'h0000_0000_0000_1234, 2'd1, OP_HEXPAD);
		queue_random(65);
		wait_idle();

		write_pad(1'b0);
		queue_random(65);
		wait_idle();

		write_pad(1'b1);
		queue_random(60);
		wait_idle();

		if (errors == 0)
			$display("integer_to_ascii_converter_test: done, clean");
		else
			$display("integer_to_ascii_converter_test: done, errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("integer_to_ascii_converter_test: done, errors");
		$finish;
	end

endmodule

FILE: integer_to_ascii_converter.f
hdl/i2a_pkg.sv
hdl/i2a_datapath.sv
hdl/i2a_ctrl.sv
hdl/integer_to_ascii_converter.sv
hdl/i2a_check.sv
dv/integer_to_ascii_converter_test.sv
